[rtl/rdd_pkg.sv]
// shared types, widths and helpers for the ray differential derivatives block
`default_nettype none

package rdd_pkg;

  // vector format
  localparam int COMP_W = 21;
  localparam int VEC_W  = 3 * COMP_W;

  // datapath widths
  localparam int DIFF_W = COMP_W + 1;
  localparam int PN_W   = COMP_W + DIFF_W;
  localparam int ND_W   = 2 * COMP_W;
  localparam int DOT_W  = PN_W + 2;
  localparam int DET_W  = ND_W + 1;
  localparam int NLO_W  = 23;
  localparam int NHI_W  = DOT_W - NLO_W;
  localparam int LO_W   = COMP_W + NLO_W + 1;
  localparam int HI_W   = COMP_W + NHI_W;
  localparam int PROD_W = 64;
  localparam int DEN_W  = DOT_W;
  localparam int QBITS  = 41;
  localparam int Q_W    = QBITS + 1;
  localparam int LIMIT_W  = 40;
  localparam int UV_W     = 32;
  localparam int UV_SHIFT = 16;

  // pipeline latencies
  localparam int DIV_LAT  = QBITS + 3;
  localparam int RAY_LAT  = 2 * DIV_LAT + 8;
  localparam int PIPE_LAT = RAY_LAT + 2;

  // dropped axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [VEC_W-1:0] vec_t;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [1:0] axis_t;

  // one component of a packed vector
  function automatic comp_t comp_of(input vec_t v, input int k);
    return comp_t'(v[k*COMP_W +: COMP_W]);
  endfunction

  // saturate a sum to the component range
  function automatic comp_t sat_comp(input logic signed [Q_W:0] v);
    if (v[Q_W:COMP_W-1] == {(Q_W-COMP_W+2){v[Q_W]}}) begin
      return comp_t'(v[COMP_W-1:0]);
    end
    return v[Q_W] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
  endfunction

  // saturate a quotient to the uv range
  function automatic logic signed [UV_W-1:0] sat_uv(input logic signed [Q_W-1:0] v);
    if (v[Q_W-1:UV_W-1] == {(Q_W-UV_W+1){v[Q_W-1]}}) begin
      return v[UV_W-1:0];
    end
    return v[Q_W-1] ? {1'b1, {(UV_W-1){1'b0}}} : {1'b0, {(UV_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

[rtl/rdd_div.sv]
// pipelined signed divider, rounded to nearest, magnitude clamped to 2^40
`default_nettype none

module rdd_div (
  input  logic                              clk,
  input  logic signed [rdd_pkg::PROD_W-1:0] num,
  input  logic signed [rdd_pkg::DEN_W-1:0]  den,
  output logic signed [rdd_pkg::Q_W-1:0]    quo
);
  import rdd_pkg::*;

  localparam logic [QBITS-1:0] QLIM = QBITS'(1) << (QBITS - 1);

  logic [PROD_W-1:0] nm0;
  logic [DEN_W-1:0]  dm0;
  logic              neg0;
  logic [PROD_W-1:0] n1;
  logic [DEN_W-1:0]  dm1;
  logic              neg1;

  logic [DEN_W-1:0]  rem_q [QBITS];
  logic [PROD_W-1:0] n_q   [QBITS];
  logic [DEN_W-1:0]  d_q   [QBITS];
  logic              neg_q [QBITS];
  logic              ovf_q [QBITS];
  logic [QBITS-1:0]  q_q   [QBITS];
  logic [QBITS-1:0]  qm;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    nm0  <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    dm0  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    neg0 <= num[PROD_W-1] ^ den[DEN_W-1];
  end

  // add half the divisor for rounding
  always_ff @(posedge clk) begin
    n1   <= nm0 + PROD_W'(dm0 >> 1);
    dm1  <= dm0;
    neg1 <= neg0;
  end

  // one quotient bit per stage
  for (genvar g = 0; g < QBITS; g++) begin : g_step
    logic [DEN_W-1:0]  rem_in;
    logic [PROD_W-1:0] n_in;
    logic [DEN_W-1:0]  d_in;
    logic              neg_in;
    logic              ovf_in;
    logic [QBITS-1:0]  q_in;
    logic [DEN_W:0]    trial;

    if (g == 0) begin : g_first
      assign rem_in = DEN_W'(n1 >> QBITS);
      assign n_in   = n1;
      assign d_in   = dm1;
      assign neg_in = neg1;
      assign ovf_in = (n1 >> QBITS) >= PROD_W'(dm1);
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_q[g-1];
      assign n_in   = n_q[g-1];
      assign d_in   = d_q[g-1];
      assign neg_in = neg_q[g-1];
      assign ovf_in = ovf_q[g-1];
      assign q_in   = q_q[g-1];
    end

    assign trial = {rem_in, n_in[QBITS-1-g]};

    always_ff @(posedge clk) begin
      if (trial >= {1'b0, d_in}) begin
        rem_q[g] <= DEN_W'(trial - {1'b0, d_in});
        q_q[g]   <= q_in | (QBITS'(1) << (QBITS - 1 - g));
      end else begin
        rem_q[g] <= DEN_W'(trial);
        q_q[g]   <= q_in;
      end
      n_q[g]   <= n_in;
      d_q[g]   <= d_in;
      neg_q[g] <= neg_in;
      ovf_q[g] <= ovf_in;
    end
  end

  // clamp and apply sign
  assign qm = (ovf_q[QBITS-1] || q_q[QBITS-1] > QLIM) ? QLIM : q_q[QBITS-1];

  always_ff @(posedge clk) begin
    quo <= neg_q[QBITS-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

endmodule

`default_nettype wire

[rtl/rdd_ray.sv]
// one offset ray: tangent plane hit, point step and 2x2 uv solve
`default_nettype none

module rdd_ray (
  input  logic                            clk,
  input  logic [rdd_pkg::LIMIT_W-1:0]     limit,
  input  rdd_pkg::vec_t                   n_vec,
  input  rdd_pkg::vec_t                   p_vec,
  input  rdd_pkg::vec_t                   tu_vec,
  input  rdd_pkg::vec_t                   tv_vec,
  input  rdd_pkg::vec_t                   o_vec,
  input  rdd_pkg::vec_t                   d_vec,
  input  rdd_pkg::axis_t                  axis,
  output rdd_pkg::vec_t                   pstep,
  output logic signed [rdd_pkg::UV_W-1:0] du,
  output logic signed [rdd_pkg::UV_W-1:0] dv,
  output logic                            ok
);
  import rdd_pkg::*;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    diff_t [2:0]              op;
    comp_t                    a00;
    comp_t                    a01;
    comp_t                    a10;
    comp_t                    a11;
    logic signed [DET_W-1:0]  det;
    logic                     par;
    logic                     sing;
    axis_t                    axis;
  } side_t;

  typedef struct packed {
    vec_t st;
    logic par;
    logic sing;
  } tail_t;

  // stage 1 signals
  diff_t                    c1_pm [3];
  diff_t                    c1_op [3];
  comp_t                    c1_a00, c1_a01, c1_a10, c1_a11;
  logic signed [PN_W-1:0]   s1_pn [3];
  logic signed [ND_W-1:0]   s1_nd [3];
  diff_t                    s1_op [3];
  comp_t                    s1_d  [3];
  comp_t                    s1_a00, s1_a01, s1_a10, s1_a11;
  logic signed [ND_W-1:0]   s1_m0, s1_m1;
  axis_t                    s1_axis;

  // stage 2 signals
  logic signed [DOT_W-1:0]  s2_num, s2_den;
  logic signed [DET_W-1:0]  s2_det;
  diff_t                    s2_op [3];
  comp_t                    s2_d  [3];
  comp_t                    s2_a00, s2_a01, s2_a10, s2_a11;
  axis_t                    s2_axis;

  // stage 3 and 4 signals
  logic [DOT_W-1:0]         c3_dmag;
  logic [DET_W-1:0]         c3_detmag;
  logic signed [LO_W-1:0]   s3_lo [3];
  logic signed [HI_W-1:0]   s3_hi [3];
  logic signed [DEN_W-1:0]  s3_den;
  side_t                    s3_side;
  logic signed [PROD_W-1:0] s4_prod [3];
  logic signed [DEN_W-1:0]  s4_den;
  side_t                    s4_side;

  // plane divide results and side line
  logic signed [Q_W-1:0]    q_p [3];
  side_t                    side_line [DIV_LAT];

  // stage 5 to 7 signals
  logic signed [Q_W:0]      c5_sum [3];
  comp_t                    s5_st [3];
  side_t                    s5_side;
  comp_t                    c6_b0, c6_b1;
  logic signed [ND_W-1:0]   s6_p0, s6_p1, s6_p2, s6_p3;
  side_t                    s6_side;
  vec_t                     s6_st;
  logic signed [DET_W-1:0]  c7_u, c7_v;
  logic signed [PROD_W-1:0] s7_nu, s7_nv;
  logic signed [DEN_W-1:0]  s7_det;
  tail_t                    s7_tail;

  // solve divide results and tail line
  logic signed [Q_W-1:0]    q_u, q_v;
  tail_t                    tail_line [DIV_LAT];

  // differences and kept tangent components
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c1_pm[k] = diff_t'(comp_of(p_vec, k)) - diff_t'(comp_of(o_vec, k));
      c1_op[k] = diff_t'(comp_of(o_vec, k)) - diff_t'(comp_of(p_vec, k));
    end
    unique case (axis)
      AXIS_X: begin
        c1_a00 = comp_of(tu_vec, 1);
        c1_a01 = comp_of(tv_vec, 1);
        c1_a10 = comp_of(tu_vec, 2);
        c1_a11 = comp_of(tv_vec, 2);
      end
      AXIS_Y: begin
        c1_a00 = comp_of(tu_vec, 0);
        c1_a01 = comp_of(tv_vec, 0);
        c1_a10 = comp_of(tu_vec, 2);
        c1_a11 = comp_of(tv_vec, 2);
      end
      default: begin
        c1_a00 = comp_of(tu_vec, 0);
        c1_a01 = comp_of(tv_vec, 0);
        c1_a10 = comp_of(tu_vec, 1);
        c1_a11 = comp_of(tv_vec, 1);
      end
    endcase
  end

  // stage 1: dot product terms and determinant products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_pn[k] <= comp_of(n_vec, k) * c1_pm[k];
      s1_nd[k] <= comp_of(n_vec, k) * comp_of(d_vec, k);
      s1_op[k] <= c1_op[k];
      s1_d[k]  <= comp_of(d_vec, k);
    end
    s1_m0   <= c1_a00 * c1_a11;
    s1_m1   <= c1_a01 * c1_a10;
    s1_a00  <= c1_a00;
    s1_a01  <= c1_a01;
    s1_a10  <= c1_a10;
    s1_a11  <= c1_a11;
    s1_axis <= axis;
  end

  // stage 2: dot product sums and determinant
  always_ff @(posedge clk) begin
    s2_num <= DOT_W'(s1_pn[0]) + DOT_W'(s1_pn[1]) + DOT_W'(s1_pn[2]);
    s2_den <= DOT_W'(s1_nd[0]) + DOT_W'(s1_nd[1]) + DOT_W'(s1_nd[2]);
    s2_det <= DET_W'(s1_m0) - DET_W'(s1_m1);
    for (int k = 0; k < 3; k++) begin
      s2_op[k] <= s1_op[k];
      s2_d[k]  <= s1_d[k];
    end
    s2_a00  <= s1_a00;
    s2_a01  <= s1_a01;
    s2_a10  <= s1_a10;
    s2_a11  <= s1_a11;
    s2_axis <= s1_axis;
  end

  // singular checks
  assign c3_dmag   = s2_den[DOT_W-1] ? DOT_W'(-s2_den) : DOT_W'(s2_den);
  assign c3_detmag = s2_det[DET_W-1] ? DET_W'(-s2_det) : DET_W'(s2_det);

  // stage 3: direction times numerator as two partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s3_lo[k]      <= s2_d[k] * $signed({1'b0, s2_num[NLO_W-1:0]});
      s3_hi[k]      <= s2_d[k] * $signed(s2_num[DOT_W-1:NLO_W]);
      s3_side.op[k] <= s2_op[k];
    end
    s3_den       <= s2_den;
    s3_side.a00  <= s2_a00;
    s3_side.a01  <= s2_a01;
    s3_side.a10  <= s2_a10;
    s3_side.a11  <= s2_a11;
    s3_side.det  <= s2_det;
    s3_side.par  <= c3_dmag <= DOT_W'(limit);
    s3_side.sing <= c3_detmag <= DET_W'(limit);
    s3_side.axis <= s2_axis;
  end

  // stage 4: combine partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s4_prod[k] <= (PROD_W'(s3_hi[k]) <<< NLO_W) + PROD_W'(s3_lo[k]);
    end
    s4_den  <= s3_den;
    s4_side <= s3_side;
  end

  // plane hit dividers, one per component
  for (genvar g = 0; g < 3; g++) begin : g_pdiv
    rdd_div u_div (
      .clk (clk),
      .num (s4_prod[g]),
      .den (s4_den),
      .quo (q_p[g])
    );
  end

  // side data follows the plane dividers
  always_ff @(posedge clk) begin
    side_line[0] <= s4_side;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c5_sum[k] = (Q_W+1)'(side_line[DIV_LAT-1].op[k]) + (Q_W+1)'(q_p[k]);
    end
  end

  // stage 5: point step components
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s5_st[k] <= sat_comp(c5_sum[k]);
    end
    s5_side <= side_line[DIV_LAT-1];
  end

  // right hand side on the kept axes
  always_comb begin
    unique case (s5_side.axis)
      AXIS_X: begin
        c6_b0 = s5_st[1];
        c6_b1 = s5_st[2];
      end
      AXIS_Y: begin
        c6_b0 = s5_st[0];
        c6_b1 = s5_st[2];
      end
      default: begin
        c6_b0 = s5_st[0];
        c6_b1 = s5_st[1];
      end
    endcase
  end

  // stage 6: cramer products
  always_ff @(posedge clk) begin
    s6_p0   <= s5_side.a11 * c6_b0;
    s6_p1   <= s5_side.a01 * c6_b1;
    s6_p2   <= s5_side.a00 * c6_b1;
    s6_p3   <= s5_side.a10 * c6_b0;
    s6_side <= s5_side;
    s6_st   <= {s5_st[2], s5_st[1], s5_st[0]};
  end

  assign c7_u = DET_W'(s6_p0) - DET_W'(s6_p1);
  assign c7_v = DET_W'(s6_p2) - DET_W'(s6_p3);

  // stage 7: scaled numerators
  always_ff @(posedge clk) begin
    s7_nu        <= PROD_W'(c7_u) <<< UV_SHIFT;
    s7_nv        <= PROD_W'(c7_v) <<< UV_SHIFT;
    s7_det       <= DEN_W'(s6_side.det);
    s7_tail.st   <= s6_st;
    s7_tail.par  <= s6_side.par;
    s7_tail.sing <= s6_side.sing;
  end

  // solve dividers
  rdd_div u_div_u (
    .clk (clk),
    .num (s7_nu),
    .den (s7_det),
    .quo (q_u)
  );

  rdd_div u_div_v (
    .clk (clk),
    .num (s7_nv),
    .den (s7_det),
    .quo (q_v)
  );

  always_ff @(posedge clk) begin
    tail_line[0] <= s7_tail;
    for (int i = 1; i < DIV_LAT; i++) begin
      tail_line[i] <= tail_line[i-1];
    end
  end

  // stage 8: masking and uv saturation
  always_ff @(posedge clk) begin
    pstep <= tail_line[DIV_LAT-1].par ? '0 : tail_line[DIV_LAT-1].st;
    if (tail_line[DIV_LAT-1].par || tail_line[DIV_LAT-1].sing) begin
      du <= '0;
      dv <= '0;
      ok <= 1'b0;
    end else begin
      du <= sat_uv(q_u);
      dv <= sat_uv(q_v);
      ok <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/ray_differential_surface_derivatives_unit.sv]
// top level of the ray differential surface derivatives block
`default_nettype none

// Takes one surface hit per clock: an item is accepted whenever start is high,
// busy is always low, and the results for that item appear on the outputs with
// done high, in order, one result per item. Between input and output lie the
// input registers, the two chained 41-step quotient pipelines of each offset
// ray (plane hit, then uv solve) and the product and saturation stages around
// them. The receiver cannot stall the pipeline; done lasts one cycle per
// result. The singular limit register is written with cfg_write and should
// only change while no item is in flight.
module ray_differential_surface_derivatives_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cfg_write,
  input  logic [rdd_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                            has_rays,
  input  logic [rdd_pkg::VEC_W-1:0]       surface_normal,
  input  logic [rdd_pkg::VEC_W-1:0]       hit_point,
  input  logic [rdd_pkg::VEC_W-1:0]       tangent_u,
  input  logic [rdd_pkg::VEC_W-1:0]       tangent_v,
  input  logic [rdd_pkg::VEC_W-1:0]       x_ray_origin,
  input  logic [rdd_pkg::VEC_W-1:0]       x_ray_direction,
  input  logic [rdd_pkg::VEC_W-1:0]       y_ray_origin,
  input  logic [rdd_pkg::VEC_W-1:0]       y_ray_direction,
  output logic                            done,
  output logic [rdd_pkg::VEC_W-1:0]       point_step_x,
  output logic [rdd_pkg::VEC_W-1:0]       point_step_y,
  output logic signed [rdd_pkg::UV_W-1:0] u_step_x,
  output logic signed [rdd_pkg::UV_W-1:0] v_step_x,
  output logic signed [rdd_pkg::UV_W-1:0] u_step_y,
  output logic signed [rdd_pkg::UV_W-1:0] v_step_y,
  output logic                            x_solved,
  output logic                            y_solved
);
  import rdd_pkg::*;

  logic [LIMIT_W-1:0] singular_limit;
  logic               in_vld;
  logic               in_has;
  vec_t               in_n, in_p, in_tu, in_tv, in_xo, in_xd, in_yo, in_yd;
  comp_t              c_nx, c_ny, c_nz;
  logic [COMP_W-1:0]  mag_x, mag_y, mag_z;
  axis_t              axis;
  logic [RAY_LAT-1:0] vld_line;
  logic [RAY_LAT-1:0] has_line;

  vec_t                    px, py;
  logic signed [UV_W-1:0]  dux, dvx, duy, dvy;
  logic                    okx, oky;

  // the pipeline never holds off an item
  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      singular_limit <= '0;
    end else if (cfg_write) begin
      singular_limit <= cfg_data;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    in_has <= has_rays;
    in_n   <= surface_normal;
    in_p   <= hit_point;
    in_tu  <= tangent_u;
    in_tv  <= tangent_v;
    in_xo  <= x_ray_origin;
    in_xd  <= x_ray_direction;
    in_yo  <= y_ray_origin;
    in_yd  <= y_ray_direction;
  end

  // dominant normal axis
  assign c_nx  = comp_of(in_n, 0);
  assign c_ny  = comp_of(in_n, 1);
  assign c_nz  = comp_of(in_n, 2);
  assign mag_x = c_nx[COMP_W-1] ? COMP_W'(-c_nx) : COMP_W'(c_nx);
  assign mag_y = c_ny[COMP_W-1] ? COMP_W'(-c_ny) : COMP_W'(c_ny);
  assign mag_z = c_nz[COMP_W-1] ? COMP_W'(-c_nz) : COMP_W'(c_nz);

  always_comb begin
    if (mag_x > mag_y && mag_x > mag_z) begin
      axis = AXIS_X;
    end else if (mag_y > mag_z) begin
      axis = AXIS_Y;
    end else begin
      axis = AXIS_Z;
    end
  end

  // the two offset rays
  rdd_ray u_ray_x (
    .clk    (clk),
    .limit  (singular_limit),
    .n_vec  (in_n),
    .p_vec  (in_p),
    .tu_vec (in_tu),
    .tv_vec (in_tv),
    .o_vec  (in_xo),
    .d_vec  (in_xd),
    .axis   (axis),
    .pstep  (px),
    .du     (dux),
    .dv     (dvx),
    .ok     (okx)
  );

  rdd_ray u_ray_y (
    .clk    (clk),
    .limit  (singular_limit),
    .n_vec  (in_n),
    .p_vec  (in_p),
    .tu_vec (in_tu),
    .tv_vec (in_tv),
    .o_vec  (in_yo),
    .d_vec  (in_yd),
    .axis   (axis),
    .pstep  (py),
    .du     (duy),
    .dv     (dvy),
    .ok     (oky)
  );

  // valid and ray-present flags travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
    end else begin
      vld_line <= {vld_line[RAY_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    has_line <= {has_line[RAY_LAT-2:0], in_has};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_line[RAY_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (has_line[RAY_LAT-1]) begin
      point_step_x <= px;
      point_step_y <= py;
      u_step_x     <= dux;
      v_step_x     <= dvx;
      u_step_y     <= duy;
      v_step_y     <= dvy;
      x_solved     <= okx;
      y_solved     <= oky;
    end else begin
      point_step_x <= '0;
      point_step_y <= '0;
      u_step_x     <= '0;
      v_step_x     <= '0;
      u_step_y     <= '0;
      v_step_y     <= '0;
      x_solved     <= 1'b0;
      y_solved     <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/rdd_check.sv]
// port-level checks for the derivatives block, bound to the top level
`default_nettype none

module rdd_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            has_rays,
  input logic                            done,
  input logic [rdd_pkg::VEC_W-1:0]       point_step_x,
  input logic signed [rdd_pkg::UV_W-1:0] u_step_x,
  input logic signed [rdd_pkg::UV_W-1:0] v_step_x,
  input logic signed [rdd_pkg::UV_W-1:0] u_step_y,
  input logic signed [rdd_pkg::UV_W-1:0] v_step_y,
  input logic                            x_solved,
  input logic                            y_solved
);
  import rdd_pkg::*;

  // the block never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted item is followed by its result with done high
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start |-> ##PIPE_LAT done)
    else $error("result missing after latency");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_LAT))
    else $error("result without item");

  // a failed solve gives zero steps
  a_unsolved_zero: assert property (@(posedge clk) disable iff (rst)
    done && (!x_solved || !y_solved) |->
      (x_solved || (u_step_x == 0 && v_step_x == 0)) &&
      (y_solved || (u_step_y == 0 && v_step_y == 0)))
    else $error("unsolved ray with nonzero step");

  // items without rays give a zero x point step and no solved flags
  a_no_rays_zero: assert property (@(posedge clk) disable iff (rst)
    done && !$past(has_rays, PIPE_LAT) |->
      point_step_x == 0 && !x_solved && !y_solved)
    else $error("item without rays gave nonzero result");

endmodule

bind ray_differential_surface_derivatives_unit rdd_check u_rdd_check (.*);

`default_nettype wire

[sim/tb.sv]
// testbench for the ray differential surface derivatives block
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdd_pkg::*;

  localparam longint COMP_MAX = (64'sd1 <<< (COMP_W - 1)) - 1;
  localparam longint COMP_MIN = -COMP_MAX - 1;
  localparam longint QUOT_CLAMP = 64'sd1 <<< 40;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam int CYCLE_LIMIT = 400000;

  typedef longint triple_t [3];

  typedef struct {
    logic has_rays;
    vec_t normal;
    vec_t point;
    vec_t tan_u;
    vec_t tan_v;
    vec_t xo;
    vec_t xd;
    vec_t yo;
    vec_t yd;
  } hit_t;

  typedef struct {
    vec_t step_x;
    vec_t step_y;
    logic signed [UV_W-1:0] ux;
    logic signed [UV_W-1:0] vx;
    logic signed [UV_W-1:0] uy;
    logic signed [UV_W-1:0] vy;
    logic solved_x;
    logic solved_y;
  } deriv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_write = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic has_rays = 1'b0;
  vec_t surface_normal = '0, hit_point = '0, tangent_u = '0, tangent_v = '0;
  vec_t x_ray_origin = '0, x_ray_direction = '0, y_ray_origin = '0, y_ray_direction = '0;
  logic done;
  vec_t point_step_x, point_step_y;
  logic signed [UV_W-1:0] u_step_x, v_step_x, u_step_y, v_step_y;
  logic x_solved, y_solved;

  logic [LIMIT_W-1:0] model_limit = '0;
  deriv_t pending_derivs[$];
  bit failed = 0;
  int sender_idle_pct = 0;
  longint unsigned cycle_count = 0;

  ray_differential_surface_derivatives_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .has_rays(has_rays), .surface_normal(surface_normal), .hit_point(hit_point),
    .tangent_u(tangent_u), .tangent_v(tangent_v),
    .x_ray_origin(x_ray_origin), .x_ray_direction(x_ray_direction),
    .y_ray_origin(y_ray_origin), .y_ray_direction(y_ray_direction),
    .done(done), .point_step_x(point_step_x), .point_step_y(point_step_y),
    .u_step_x(u_step_x), .v_step_x(v_step_x), .u_step_y(u_step_y), .v_step_y(v_step_y),
    .x_solved(x_solved), .y_solved(y_solved)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic void split_vec(input vec_t w, output triple_t v);
    for (int k = 0; k < 3; k++) begin
      v[k] = longint'($signed(w[k*COMP_W +: COMP_W]));
    end
  endfunction

  function automatic vec_t pack_vec(input longint x, input longint y, input longint z);
    logic [63:0] ux, uy, uz;
    ux = x;
    uy = y;
    uz = z;
    return {uz[COMP_W-1:0], uy[COMP_W-1:0], ux[COMP_W-1:0]};
  endfunction

  function automatic longint unsigned abs_u(input longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rounded quotient, ties away from zero, magnitude capped at 2^40
  function automatic longint round_quot(input longint num, input longint den);
    longint unsigned dm, q;
    dm = abs_u(den);
    q = (abs_u(num) + dm / 2) / dm;
    if (q > QUOT_CLAMP) q = QUOT_CLAMP;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // intersect one offset ray with the tangent plane and solve for uv steps
  function automatic void offset_ray_steps(input triple_t n, input triple_t p,
      input triple_t tu, input triple_t tv, input int a0, input int a1,
      input vec_t ow, input vec_t dw, output vec_t pstep,
      output logic signed [UV_W-1:0] du, output logic signed [UV_W-1:0] dv,
      output logic ok);
    triple_t o, d, st;
    longint num, den, det, b0, b1;
    num = 0;
    den = 0;
    pstep = '0;
    du = '0;
    dv = '0;
    ok = 1'b0;
    split_vec(ow, o);
    split_vec(dw, d);
    for (int k = 0; k < 3; k++) begin
      num += n[k] * (p[k] - o[k]);
      den += n[k] * d[k];
    end
    if (abs_u(den) <= model_limit) return;
    for (int k = 0; k < 3; k++) begin
      st[k] = clamp((o[k] - p[k]) + round_quot(d[k] * num, den), COMP_MIN, COMP_MAX);
    end
    pstep = pack_vec(st[0], st[1], st[2]);
    b0 = st[a0];
    b1 = st[a1];
    det = tu[a0] * tv[a1] - tv[a0] * tu[a1];
    if (abs_u(det) <= model_limit) return;
    du = UV_W'(clamp(round_quot((tv[a1] * b0 - tv[a0] * b1) * 65536, det),
                     -64'sd2147483648, 64'sd2147483647));
    dv = UV_W'(clamp(round_quot((tu[a0] * b1 - tu[a1] * b0) * 65536, det),
                     -64'sd2147483648, 64'sd2147483647));
    ok = 1'b1;
  endfunction

  function automatic deriv_t predict_derivs(input hit_t h);
    deriv_t r;
    triple_t n, p, tu, tv;
    longint unsigned mx, my, mz;
    int a0, a1;
    r = '{default: '0};
    if (!h.has_rays) return r;
    split_vec(h.normal, n);
    split_vec(h.point, p);
    split_vec(h.tan_u, tu);
    split_vec(h.tan_v, tv);
    mx = abs_u(n[0]);
    my = abs_u(n[1]);
    mz = abs_u(n[2]);
    // drop the dominant normal axis
    if (mx > my && mx > mz) begin
      a0 = 1; a1 = 2;
    end else if (my > mz) begin
      a0 = 0; a1 = 2;
    end else begin
      a0 = 0; a1 = 1;
    end
    offset_ray_steps(n, p, tu, tv, a0, a1, h.xo, h.xd, r.step_x, r.ux, r.vx, r.solved_x);
    offset_ray_steps(n, p, tu, tv, a0, a1, h.yo, h.yd, r.step_y, r.uy, r.vy, r.solved_y);
    return r;
  endfunction

  // ---------------- result checking ----------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %h got %h", name, want, got);
      failed = 1;
    end
  endfunction

  always @(posedge clk) begin
    deriv_t e;
    if (!rst && done) begin
      if (pending_derivs.size() == 0) begin
        $error("result with no item outstanding");
        failed = 1;
      end else begin
        e = pending_derivs.pop_front();
        check_field("point_step_x", e.step_x, point_step_x);
        check_field("point_step_y", e.step_y, point_step_y);
        check_field("u_step_x", e.ux, u_step_x);
        check_field("v_step_x", e.vx, v_step_x);
        check_field("u_step_y", e.uy, u_step_y);
        check_field("v_step_y", e.vy, v_step_y);
        check_field("x_solved", e.solved_x, x_solved);
        check_field("y_solved", e.solved_y, y_solved);
      end
    end
  end

  // ---------------- driving ----------------

  task automatic send_item(input hit_t h);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    has_rays <= h.has_rays;
    surface_normal <= h.normal;
    hit_point <= h.point;
    tangent_u <= h.tan_u;
    tangent_v <= h.tan_v;
    x_ray_origin <= h.xo;
    x_ray_direction <= h.xd;
    y_ray_origin <= h.yo;
    y_ray_direction <= h.yd;
    do @(posedge clk); while (busy);
    pending_derivs.push_back(predict_derivs(h));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_derivs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    model_limit = value;
  endtask

  // ---------------- item generation ----------------

  function automatic longint rand_small(input int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  function automatic longint rand_extreme();
    case ($urandom_range(4))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic vec_t rand_vec(input int kind);
    case (kind)
      0: return pack_vec(rand_small(2048), rand_small(2048), rand_small(2048));
      1: return pack_vec(rand_extreme(), rand_extreme(), rand_extreme());
      default: return VEC_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // random hit: mostly a unit-ish normal with modest tangents and rays, else extreme or random fields
  function automatic hit_t rand_hit();
    hit_t h;
    int kind, ax;
    longint nv [3];
    kind = $urandom_range(9);
    h.has_rays = (kind == 9) ? 1'b0 : 1'b1;
    if (kind <= 5) begin
      ax = $urandom_range(2);
      for (int k = 0; k < 3; k++) nv[k] = rand_small(512);
      nv[ax] = ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(512, 4096));
      h.normal = pack_vec(nv[0], nv[1], nv[2]);
      kind = 0;
    end else begin
      kind = (kind == 8) ? 1 : 2;
      h.normal = rand_vec(kind);
    end
    h.point = rand_vec(kind);
    h.tan_u = rand_vec(kind);
    h.tan_v = rand_vec(kind);
    h.xo = rand_vec(kind);
    h.xd = rand_vec(kind);
    h.yo = rand_vec(kind);
    h.yd = rand_vec(kind);
    return h;
  endfunction

  function automatic hit_t make_hit(input vec_t n, input vec_t p, input vec_t tu,
      input vec_t tv, input vec_t xo, input vec_t xd, input vec_t yo, input vec_t yd);
    hit_t h;
    h.has_rays = 1'b1;
    h.normal = n; h.point = p; h.tan_u = tu; h.tan_v = tv;
    h.xo = xo; h.xd = xd; h.yo = yo; h.yd = yd;
    return h;
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed();
    hit_t h;
    vec_t ex, ey, ez, zero, cmin, cmax;
    ex = pack_vec(1024, 0, 0);
    ey = pack_vec(0, 1024, 0);
    ez = pack_vec(0, 0, 1024);
    zero = '0;
    cmin = pack_vec(COMP_MIN, COMP_MIN, COMP_MIN);
    cmax = pack_vec(COMP_MAX, COMP_MAX, COMP_MAX);
    // no rays: everything zero
    h = rand_hit();
    h.has_rays = 1'b0;
    send_item(h);
    // normal dominant on z, x and y
    send_item(make_hit(ez, zero, ex, ey, pack_vec(0, 0, 1024), pack_vec(64, 0, -1024),
                       pack_vec(0, 0, 1024), pack_vec(0, 64, -1024)));
    send_item(make_hit(ex, zero, ey, ez, pack_vec(1024, 0, 0), pack_vec(-1024, 64, 0),
                       pack_vec(1024, 0, 0), pack_vec(-1024, 0, 64)));
    send_item(make_hit(ey, zero, ex, ez, pack_vec(0, 1024, 0), pack_vec(64, -1024, 0),
                       pack_vec(0, 1024, 0), pack_vec(0, -1024, 64)));
    // ties between normal components
    send_item(make_hit(pack_vec(1024, 1024, 0), zero, ex, ey, ez, pack_vec(-500, -700, 30),
                       ey, pack_vec(-300, -900, 5)));
    send_item(make_hit(pack_vec(-1024, 1024, -1024), zero, ex, ez, ez,
                       pack_vec(300, -800, 100), ex, pack_vec(900, -100, 200)));
    // parallel rays
    send_item(make_hit(ez, zero, ex, ey, ez, ex, ez, ey));
    // singular system, point step still given
    send_item(make_hit(ez, zero, ex, ex, ez, pack_vec(64, 0, -1024),
                       ez, pack_vec(0, 64, -1024)));
    // point step saturation
    send_item(make_hit(cmax, cmin, ex, ey, cmax, pack_vec(COMP_MAX, COMP_MIN, 1),
                       cmin, pack_vec(COMP_MIN, 2, -1)));
    // uv saturation with a tiny determinant
    send_item(make_hit(ez, zero, pack_vec(1, 0, 0), pack_vec(0, 1, 0), pack_vec(0, 0, 4096),
                       pack_vec(COMP_MAX, COMP_MIN, -1), pack_vec(0, 0, 4096),
                       pack_vec(COMP_MIN, COMP_MAX, -1)));
    // field extremes
    send_item(make_hit(cmin, cmin, cmin, cmin, cmin, cmin, cmin, cmin));
    send_item(make_hit(cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax));
    send_item(make_hit('1, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_hit(zero, zero, zero, zero, zero, zero, zero, zero));
    send_item(make_hit(cmax, cmin, cmax, cmin, cmax, cmin, cmax, cmin));
  endtask

  task automatic test_random(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) sender_idle_pct = 0;
      else sender_idle_pct = idle_pct;
      send_item(rand_hit());
    end
    sender_idle_pct = 0;
  endtask

  // ---------------- run ----------------

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(300, 0);

    write_limit(LIMIT_MAX);
    test_directed();
    test_random(100, 73);

    write_limit(40'd1 + 40'($urandom_range(1000)));
    test_random(300, 73);

    write_limit({$urandom(), 8'($urandom())} >> $urandom_range(39));
    test_random(250, 30);

    write_limit('0);
    test_directed();
    test_random(250, 30);

    wait_drained();
    if (!failed && pending_derivs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
